FILE: rtl/core/multi_timer_table_defines.svh
// ----------------------------------------------------------------------------
// multi_timer_table_defines
// assertion macros used by the timer table engine
// ----------------------------------------------------------------------------
`ifndef MULTI_TIMER_TABLE_DEFINES_SVH
`define MULTI_TIMER_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF

`define MTT_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

`define MTT_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define MTT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MTT_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define MTT_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define MTT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: rtl/core/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg
// shared types, opcodes and result codes of the timer table
// ----------------------------------------------------------------------------
`default_nettype none

package mtt_pkg;

    localparam int OP_W   = 3;
    localparam int KIND_W = 2;
    localparam int ID_W   = 16;
    localparam int TMO_W  = 32;
    localparam int TIME_W = 40;
    localparam int REM_W  = 32;

    localparam logic [OP_W-1:0] OP_SET     = 3'd0;
    localparam logic [OP_W-1:0] OP_RESTART = 3'd1;
    localparam logic [OP_W-1:0] OP_CANCEL  = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd3;
    localparam logic [OP_W-1:0] OP_EXPIRE  = 3'd4;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd5;

    localparam logic [KIND_W-1:0] KIND_OK      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERR     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REPORT  = 2'd3;

    localparam logic [REM_W-1:0] REM_SAT  = 32'h7FFF_FFFF;
    localparam logic [REM_W-1:0] REM_NONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] alarm;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [REM_W-1:0]  rem;
        logic              last;
    } result_t;

    typedef struct packed {
        logic    emit;
        result_t res;
    } beat_t;

endpackage

`default_nettype wire

FILE: rtl/core/mtt_ram.sv
// ----------------------------------------------------------------------------
// mtt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mtt_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/mtt_engine.sv
// ----------------------------------------------------------------------------
// mtt_engine
// command sequencer: takes one command, walks the entry ram one slot a cycle,
// unless a beat waits on a busy output register, compacts the table in place
// and hands result beats to the output register
`default_nettype none
`include "multi_timer_table_defines.svh"

module mtt_engine #(
    parameter int TIMER_SLOTS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [mtt_pkg::OP_W-1:0]      s_opcode,
    input  wire logic [mtt_pkg::ID_W-1:0]      s_timer_id,
    input  wire logic [mtt_pkg::TMO_W-1:0]     s_timeout_ms,
    input  wire logic                          out_free,
    output mtt_pkg::beat_t                     beat_o,
    output logic                               ram_wr_en,
    output logic [((TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1)-1:0] ram_wr_addr,
    output logic [mtt_pkg::ENTRY_W-1:0]        ram_wr_data,
    output logic [((TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1)-1:0] ram_rd_addr,
    input  wire logic [mtt_pkg::ENTRY_W-1:0]   ram_rd_data
);

    localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam logic [CW-1:0] FULL = CW'(TIMER_SLOTS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SET  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]                     state_reg, state_next;
    logic [mtt_pkg::OP_W-1:0]       op_reg, op_next;
    logic [mtt_pkg::ID_W-1:0]       tid_reg, tid_next;
    logic [mtt_pkg::TMO_W-1:0]      tmo_reg, tmo_next;
    logic [mtt_pkg::TIME_W-1:0]     now_reg, now_next;
    logic [mtt_pkg::ID_W-1:0]       idc_reg, idc_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [CW-1:0]                  r_reg, r_next;
    logic [CW-1:0]                  w_reg, w_next;
    logic                           found_reg, found_next;
    logic [mtt_pkg::REM_W-1:0]      best_reg, best_next;

    mtt_pkg::entry_t                cur;
    mtt_pkg::entry_t                new_entry;
    logic [mtt_pkg::TIME_W-1:0]     diff;
    logic [mtt_pkg::TIME_W-1:0]     arm;
    logic [mtt_pkg::REM_W-1:0]      sat_diff;
    logic [mtt_pkg::ID_W-1:0]       idc_inc;
    logic [CW-1:0]                  r_inc;
    logic [CW-1:0]                  rd_sel;
    logic                           expired;
    logic                           in_range;
    logic                           match;
    logic                           finish;
    logic                           need_out;
    logic                           adv;
    logic                           accept;

    assign cur      = mtt_pkg::entry_t'(ram_rd_data);
    assign diff     = cur.alarm - now_reg;
    assign expired  = (diff == '0) || diff[mtt_pkg::TIME_W-1];
    assign sat_diff = (|diff[mtt_pkg::TIME_W-1:mtt_pkg::REM_W-1]) ? mtt_pkg::REM_SAT
                                                                  : diff[mtt_pkg::REM_W-1:0];
    assign arm      = now_reg + mtt_pkg::TIME_W'(tmo_reg);
    assign idc_inc  = idc_reg + mtt_pkg::ID_W'(1);
    assign in_range = r_reg < cnt_reg;
    assign match    = cur.id == tid_reg;
    assign r_inc    = r_reg + CW'(1);
    assign accept   = s_valid && s_ready;

    // early exit on first restart hit or first expired entry of a query
    assign finish   = !in_range
                      || (in_range && (op_reg == mtt_pkg::OP_RESTART) && match)
                      || (in_range && (op_reg == mtt_pkg::OP_QUERY) && expired);
    assign need_out = finish || (in_range && (op_reg == mtt_pkg::OP_EXPIRE) && expired);
    assign adv      = !need_out || out_free;
    assign rd_sel   = adv ? r_inc : r_reg;

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        tid_next    = tid_reg;
        tmo_next    = tmo_reg;
        now_next    = now_reg;
        idc_next    = idc_reg;
        cnt_next    = cnt_reg;
        r_next      = r_reg;
        w_next      = w_reg;
        found_next  = found_reg;
        best_next   = best_reg;
        s_ready     = 1'b0;
        beat_o      = '0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = w_reg[AW-1:0];
        new_entry   = cur;
        ram_rd_addr = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = s_opcode;
                    tid_next   = s_timer_id;
                    tmo_next   = s_timeout_ms;
                    r_next     = '0;
                    w_next     = '0;
                    found_next = 1'b0;
                    best_next  = mtt_pkg::REM_SAT;
                    unique case (s_opcode)
                        mtt_pkg::OP_SET: begin
                            state_next = ST_SET;
                        end
                        mtt_pkg::OP_RESTART, mtt_pkg::OP_CANCEL,
                        mtt_pkg::OP_QUERY, mtt_pkg::OP_EXPIRE: begin
                            state_next = ST_SCAN;
                        end
                        mtt_pkg::OP_TICK: begin
                            now_next = now_reg + mtt_pkg::TIME_W'(1);
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SET: begin
                if (out_free) begin
                    state_next       = ST_IDLE;
                    beat_o.emit      = 1'b1;
                    beat_o.res.last  = 1'b1;
                    if (cnt_reg == FULL) begin
                        beat_o.res.kind = mtt_pkg::KIND_ERR;
                    end else begin
                        ram_wr_en       = 1'b1;
                        ram_wr_addr     = cnt_reg[AW-1:0];
                        new_entry.id    = idc_inc;
                        new_entry.alarm = arm;
                        idc_next        = idc_inc;
                        cnt_next        = cnt_reg + CW'(1);
                        beat_o.res.kind = mtt_pkg::KIND_OK;
                        beat_o.res.id   = idc_inc;
                    end
                end
            end

            ST_SCAN: begin
                ram_rd_addr = rd_sel[AW-1:0];
                if (adv) begin
                    if (finish) begin
                        state_next      = ST_IDLE;
                        beat_o.emit     = 1'b1;
                        beat_o.res.last = 1'b1;
                        unique case (op_reg)
                            mtt_pkg::OP_RESTART: begin
                                if (in_range) begin
                                    ram_wr_en       = 1'b1;
                                    ram_wr_addr     = r_reg[AW-1:0];
                                    new_entry.alarm = arm;
                                    beat_o.res.kind = mtt_pkg::KIND_OK;
                                    beat_o.res.id   = tid_reg;
                                end else begin
                                    beat_o.res.kind = mtt_pkg::KIND_ERR;
                                end
                            end
                            mtt_pkg::OP_CANCEL: begin
                                cnt_next = w_reg;
                                if (found_reg) begin
                                    beat_o.res.kind = mtt_pkg::KIND_OK;
                                    beat_o.res.id   = tid_reg;
                                end else begin
                                    beat_o.res.kind = mtt_pkg::KIND_ERR;
                                end
                            end
                            mtt_pkg::OP_QUERY: begin
                                beat_o.res.kind = mtt_pkg::KIND_REPORT;
                                if (in_range) begin
                                    beat_o.res.rem = '0;
                                end else if (cnt_reg == '0) begin
                                    beat_o.res.rem = mtt_pkg::REM_NONE;
                                end else begin
                                    beat_o.res.rem = best_reg;
                                end
                            end
                            mtt_pkg::OP_EXPIRE: begin
                                cnt_next        = w_reg;
                                beat_o.res.kind = mtt_pkg::KIND_REPORT;
                            end
                            default: begin
                                beat_o.res.kind = mtt_pkg::KIND_ERR;
                            end
                        endcase
                    end else begin
                        r_next = r_inc;
                        unique case (op_reg)
                            mtt_pkg::OP_CANCEL: begin
                                if (match && !found_reg) begin
                                    found_next = 1'b1;
                                end else begin
                                    ram_wr_en = 1'b1;
                                    w_next    = w_reg + CW'(1);
                                end
                            end
                            mtt_pkg::OP_QUERY: begin
                                if (sat_diff < best_reg) begin
                                    best_next = sat_diff;
                                end
                            end
                            mtt_pkg::OP_EXPIRE: begin
                                if (expired) begin
                                    beat_o.emit     = 1'b1;
                                    beat_o.res.kind = mtt_pkg::KIND_EXPIRED;
                                    beat_o.res.id   = cur.id;
                                end else begin
                                    ram_wr_en = 1'b1;
                                    w_next    = w_reg + CW'(1);
                                end
                            end
                            default: begin
                                r_next = r_inc;
                            end
                        endcase
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_wr_data = new_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            now_reg   <= '0;
            idc_reg   <= '0;
            cnt_reg   <= '0;
            r_reg     <= '0;
            w_reg     <= '0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            now_reg   <= now_next;
            idc_reg   <= idc_next;
            cnt_reg   <= cnt_next;
            r_reg     <= r_next;
            w_reg     <= w_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        tid_reg  <= tid_next;
        tmo_reg  <= tmo_next;
        best_reg <= best_next;
    end

    `MTT_ASSERT_ALWAYS(a_cnt_bound, aclk, aresetn, cnt_reg <= FULL,
        "fill count beyond table size")
    `MTT_ASSERT_IMPLIES(a_wr_behind_rd, aclk, aresetn, state_reg == ST_SCAN,
        (w_reg <= r_reg) && (r_reg <= cnt_reg), "compaction pointers out of order")
    `MTT_ASSERT_IMPLIES(a_emit_free, aclk, aresetn, beat_o.emit, out_free,
        "result beat while output register busy")
    `MTT_ASSERT_IMPLIES(a_idle_no_write, aclk, aresetn, state_reg == ST_IDLE, !ram_wr_en,
        "entry write while idle")
    `MTT_ASSERT_NEXT(a_now_hold, aclk, aresetn,
        !(accept && (s_opcode == mtt_pkg::OP_TICK)), $stable(now_reg),
        "clock moved without tick")

endmodule

`default_nettype wire

FILE: rtl/core/multi_timer_table.sv
// ----------------------------------------------------------------------------
// multi_timer_table
// one-shot millisecond timer table in insertion order with a millisecond
// clock advanced by tick commands; entries live in a ram, results leave through a register
// ----------------------------------------------------------------------------
//  channel | ports                                      | direction
//  s_      | s_opcode, s_timer_id, s_timeout_ms         | command beat in
//  m_      | m_kind, m_result_id, m_remaining_ms, m_last | result beat out
//
//  tick and unused opcodes finish in idle; set passes through the set state
//  restart, cancel, query, expire walk the table: a full walk visits every
//  live entry and one slot past the end, a restart or query hit ends the
//  walk there; one slot a cycle, set by the single ram read port, except that
//  a busy output register (m_ready low) stalls set and walk steps that emit
//  reset: synchronous; a fill count marks live entries, so no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module multi_timer_table #(
    parameter int TIMER_SLOTS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [mtt_pkg::OP_W-1:0]         s_opcode,
    input  wire logic [mtt_pkg::ID_W-1:0]         s_timer_id,
    input  wire logic [mtt_pkg::TMO_W-1:0]        s_timeout_ms,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [mtt_pkg::KIND_W-1:0]       m_kind,
    output logic      [mtt_pkg::ID_W-1:0]         m_result_id,
    output logic signed [mtt_pkg::REM_W-1:0]      m_remaining_ms,
    output logic                                  m_last
);

    localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    mtt_pkg::beat_t               beat;
    mtt_pkg::result_t             res_reg;
    logic                         m_valid_reg;
    logic                         out_free;
    logic                         ram_wr_en;
    logic [AW-1:0]                ram_wr_addr;
    logic [mtt_pkg::ENTRY_W-1:0]  ram_wr_data;
    logic [AW-1:0]                ram_rd_addr;
    logic [mtt_pkg::ENTRY_W-1:0]  ram_rd_data;

    assign out_free = !m_valid_reg || m_ready;

    mtt_ram #(
        .WIDTH (mtt_pkg::ENTRY_W),
        .DEPTH (TIMER_SLOTS)
    ) u_entry_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    mtt_engine #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_timer_id   (s_timer_id),
        .s_timeout_ms (s_timeout_ms),
        .out_free     (out_free),
        .beat_o       (beat),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (beat.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat.emit) begin
            res_reg <= beat.res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = res_reg.kind;
    assign m_result_id    = res_reg.id;
    assign m_remaining_ms = signed'(res_reg.rem);
    assign m_last         = res_reg.last;

endmodule

`default_nettype wire

FILE: bench/multi_timer_table_tb.sv
// ----------------------------------------------------------------------------
// multi_timer_table_tb
// Self-checking bench for the one-shot timer table. A scripted opening checks
// the empty table, zero and maximum timeouts, ignored opcodes, a full table
// and unknown ids. Random commands follow, mostly aimed at live timer ids,
// with random gaps on both channels and one long result-side stall. Every
// result beat is checked against a scripted want or the behavioral table.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_timer_table_tb;

    localparam int SLOTS = 16;
    localparam int RANDOM_ITEMS = 290;

    localparam logic [mtt_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [mtt_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

    typedef struct packed {
        logic [mtt_pkg::OP_W-1:0]  op;
        logic [mtt_pkg::ID_W-1:0]  id;
        logic [mtt_pkg::TMO_W-1:0] tmo;
        int                        reps;
        logic                      typed;
        mtt_pkg::result_t          want;
    } step_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic [mtt_pkg::OP_W-1:0] s_opcode = '0;
    logic [mtt_pkg::ID_W-1:0] s_timer_id = '0;
    logic [mtt_pkg::TMO_W-1:0] s_timeout_ms = '0;
    logic m_ready = 1'b0;
    wire s_ready;
    wire m_valid;
    wire [mtt_pkg::KIND_W-1:0] m_kind;
    wire [mtt_pkg::ID_W-1:0] m_result_id;
    wire signed [mtt_pkg::REM_W-1:0] m_remaining_ms;
    wire m_last;

    // behavioral copy of the table
    logic [mtt_pkg::TIME_W-1:0] clock_ms = '0;
    logic [mtt_pkg::ID_W-1:0] last_id = '0;
    int live = 0;
    logic [mtt_pkg::ID_W-1:0] slot_id [SLOTS];
    logic [mtt_pkg::TIME_W-1:0] slot_alarm [SLOTS];

    mtt_pkg::result_t step_results [$];
    mtt_pkg::result_t owed_results [$];

    int mismatches = 0;
    int beats_seen = 0;
    bit idle_on = 1'b1;
    int ready_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    step_row_t script [0:23];

    multi_timer_table #(
        .TIMER_SLOTS(SLOTS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_opcode(s_opcode),
        .s_timer_id(s_timer_id),
        .s_timeout_ms(s_timeout_ms),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_kind(m_kind),
        .m_result_id(m_result_id),
        .m_remaining_ms(m_remaining_ms),
        .m_last(m_last)
    );

    always #4 aclk = ~aclk;

    function automatic mtt_pkg::result_t make_result(logic [mtt_pkg::KIND_W-1:0] kind,
                                                     logic [mtt_pkg::ID_W-1:0] id,
                                                     logic [mtt_pkg::REM_W-1:0] rem,
                                                     logic last);
        mtt_pkg::result_t r;
        r.kind = kind;
        r.id = id;
        r.rem = rem;
        r.last = last;
        return r;
    endfunction

    function automatic bit is_due(logic [mtt_pkg::TIME_W-1:0] left);
        return left == '0 || left[mtt_pkg::TIME_W-1];
    endfunction

    function automatic int find_timer(logic [mtt_pkg::ID_W-1:0] id);
        for (int i = 0; i < live; i++) begin
            if (slot_id[i] == id) return i;
        end
        return -1;
    endfunction

    function automatic void drop_timer(int at);
        for (int j = at; j + 1 < live; j++) begin
            slot_id[j] = slot_id[j + 1];
            slot_alarm[j] = slot_alarm[j + 1];
        end
        live--;
    endfunction

    function automatic void table_step(logic [mtt_pkg::OP_W-1:0] op,
                                       logic [mtt_pkg::ID_W-1:0] id,
                                       logic [mtt_pkg::TMO_W-1:0] tmo);
        int hit;
        int i;
        logic [mtt_pkg::TIME_W-1:0] left;
        logic [mtt_pkg::REM_W-1:0] best;
        step_results.delete();
        case (op)
            mtt_pkg::OP_SET: begin
                if (live >= SLOTS) begin
                    step_results.push_back(make_result(mtt_pkg::KIND_ERR, '0, '0, 1'b1));
                end else begin
                    last_id = last_id + 1'b1;
                    slot_id[live] = last_id;
                    slot_alarm[live] = clock_ms + {8'd0, tmo};
                    live++;
                    step_results.push_back(make_result(mtt_pkg::KIND_OK, last_id, '0, 1'b1));
                end
            end
            mtt_pkg::OP_RESTART, mtt_pkg::OP_CANCEL: begin
                hit = find_timer(id);
                if (hit < 0) begin
                    step_results.push_back(make_result(mtt_pkg::KIND_ERR, '0, '0, 1'b1));
                end else begin
                    if (op == mtt_pkg::OP_RESTART) slot_alarm[hit] = clock_ms + {8'd0, tmo};
                    else drop_timer(hit);
                    step_results.push_back(make_result(mtt_pkg::KIND_OK, id, '0, 1'b1));
                end
            end
            mtt_pkg::OP_QUERY: begin
                best = mtt_pkg::REM_SAT;
                for (i = 0; i < live; i++) begin
                    left = slot_alarm[i] - clock_ms;
                    if (is_due(left)) begin
                        best = '0;
                        break;
                    end
                    if (left < {8'd0, best}) best = left[mtt_pkg::REM_W-1:0];
                end
                if (live == 0) best = mtt_pkg::REM_NONE;
                step_results.push_back(make_result(mtt_pkg::KIND_REPORT, '0, best, 1'b1));
            end
            mtt_pkg::OP_EXPIRE: begin
                i = 0;
                while (i < live) begin
                    left = slot_alarm[i] - clock_ms;
                    if (is_due(left)) begin
                        step_results.push_back(
                            make_result(mtt_pkg::KIND_EXPIRED, slot_id[i], '0, 1'b0));
                        drop_timer(i);
                    end else begin
                        i++;
                    end
                end
                step_results.push_back(make_result(mtt_pkg::KIND_REPORT, '0, '0, 1'b1));
            end
            mtt_pkg::OP_TICK: begin
                clock_ms = clock_ms + 1'b1;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [mtt_pkg::ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (live != 0 && r < 7) return slot_id[$urandom_range(0, live - 1)];
        if (r == 7) return last_id + 1'b1;
        return mtt_pkg::ID_W'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [mtt_pkg::TMO_W-1:0] pick_timeout();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) return $urandom_range(0, 25);
        if (r < 17) return $urandom_range(0, 500);
        return $urandom;
    endfunction

    function automatic step_row_t row(logic [mtt_pkg::OP_W-1:0] op,
                                      logic [mtt_pkg::ID_W-1:0] id,
                                      logic [mtt_pkg::TMO_W-1:0] tmo, int reps = 1);
        step_row_t s;
        s = '0;
        s.op = op;
        s.id = id;
        s.tmo = tmo;
        s.reps = reps;
        return s;
    endfunction

    function automatic step_row_t row_chk(logic [mtt_pkg::OP_W-1:0] op,
                                          logic [mtt_pkg::ID_W-1:0] id,
                                          logic [mtt_pkg::TMO_W-1:0] tmo,
                                          logic [mtt_pkg::KIND_W-1:0] kind,
                                          logic [mtt_pkg::ID_W-1:0] rid,
                                          logic [mtt_pkg::REM_W-1:0] rem);
        step_row_t s;
        s = row(op, id, tmo);
        s.typed = 1'b1;
        s.want = make_result(kind, rid, rem, 1'b1);
        return s;
    endfunction

    task automatic issue(input logic [mtt_pkg::OP_W-1:0] op,
                         input logic [mtt_pkg::ID_W-1:0] id,
                         input logic [mtt_pkg::TMO_W-1:0] tmo, input logic typed = 1'b0,
                         input mtt_pkg::result_t want = '0);
        s_opcode <= op;
        s_timer_id <= id;
        s_timeout_ms <= tmo;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        table_step(op, id, tmo);
        if (typed) owed_results.push_back(want);
        else foreach (step_results[k]) owed_results.push_back(step_results[k]);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat (gap_len()) @(posedge aclk);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 40) $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // result side: random stalls plus one long hold-off that backs up the table
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && beats_seen >= 60) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            m_ready <= 1'b0;
        end else if (!idle_on) begin
            m_ready <= 1'b1;
        end else if (ready_gap != 0) begin
            m_ready <= 1'b0;
            ready_gap <= ready_gap - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) ready_gap <= gap_len();
        end
    end

    always @(posedge aclk) begin
        mtt_pkg::result_t due;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 40)
                    $error("unexpected result beat: kind %0h id %0h", m_kind, m_result_id);
            end else begin
                due = owed_results.pop_front();
                check_field("m_kind", 32'(due.kind), 32'(m_kind));
                check_field("m_result_id", 32'(due.id), 32'(m_result_id));
                check_field("m_remaining_ms", due.rem, m_remaining_ms);
                check_field("m_last", 32'(due.last), 32'(m_last));
            end
        end
    end

    initial begin
        #200_000_000;
        $display("multi_timer_table_tb: done, errors");
        $finish;
    end

    initial begin
        int done_items;
        int r;
        int waited;
        logic [mtt_pkg::OP_W-1:0] op;

        script = '{
            row_chk(mtt_pkg::OP_QUERY, 16'h0000, 32'h0, mtt_pkg::KIND_REPORT, 16'd0,
                    mtt_pkg::REM_NONE),
            row_chk(mtt_pkg::OP_EXPIRE, 16'h0000, 32'h0, mtt_pkg::KIND_REPORT, 16'd0, 32'd0),
            row_chk(mtt_pkg::OP_RESTART, 16'h1234, 32'hA5A5_5A5A, mtt_pkg::KIND_ERR, 16'd0,
                    32'd0),
            row_chk(mtt_pkg::OP_CANCEL, 16'hFFFF, 32'h0, mtt_pkg::KIND_ERR, 16'd0, 32'd0),
            row_chk(mtt_pkg::OP_SET, 16'h0000, 32'h0, mtt_pkg::KIND_OK, 16'd1, 32'd0),
            row_chk(mtt_pkg::OP_QUERY, 16'h0000, 32'h0, mtt_pkg::KIND_REPORT, 16'd0, 32'd0),
            row_chk(mtt_pkg::OP_SET, 16'h0000, 32'hFFFF_FFFF, mtt_pkg::KIND_OK, 16'd2, 32'd0),
            row_chk(mtt_pkg::OP_SET, 16'h0000, 32'd5, mtt_pkg::KIND_OK, 16'd3, 32'd0),
            row_chk(mtt_pkg::OP_SET, 16'h0000, 32'h8000_0000, mtt_pkg::KIND_OK, 16'd4, 32'd0),
            row(OP_SPARE_A, 16'h0000, 32'h0),
            row(OP_SPARE_B, 16'hFFFF, 32'hFFFF_FFFF),
            row(mtt_pkg::OP_EXPIRE, 16'h0000, 32'h0),
            row(mtt_pkg::OP_QUERY, 16'h0000, 32'h0),
            row_chk(mtt_pkg::OP_RESTART, 16'd3, 32'd1, mtt_pkg::KIND_OK, 16'd3, 32'd0),
            row_chk(mtt_pkg::OP_CANCEL, 16'd4, 32'h0, mtt_pkg::KIND_OK, 16'd4, 32'd0),
            row(mtt_pkg::OP_TICK, 16'h0000, 32'h0),
            row(mtt_pkg::OP_QUERY, 16'h0000, 32'h0),
            row(mtt_pkg::OP_EXPIRE, 16'h0000, 32'h0),
            row_chk(mtt_pkg::OP_QUERY, 16'h0000, 32'h0, mtt_pkg::KIND_REPORT, 16'd0,
                    mtt_pkg::REM_SAT),
            row(mtt_pkg::OP_SET, 16'h0000, 32'd100, SLOTS),
            row_chk(mtt_pkg::OP_SET, 16'h0000, 32'd7, mtt_pkg::KIND_ERR, 16'd0, 32'd0),
            row_chk(mtt_pkg::OP_CANCEL, 16'd2, 32'h0, mtt_pkg::KIND_OK, 16'd2, 32'd0),
            row(mtt_pkg::OP_EXPIRE, 16'h0000, 32'h0),
            row(mtt_pkg::OP_QUERY, 16'h0000, 32'h0)
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            repeat (script[i].reps)
                issue(script[i].op, script[i].id, script[i].tmo, script[i].typed,
                      script[i].want);
        end

        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            if (done_items % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 25) op = mtt_pkg::OP_SET;
            else if (r < 37) op = mtt_pkg::OP_RESTART;
            else if (r < 49) op = mtt_pkg::OP_CANCEL;
            else if (r < 58) op = mtt_pkg::OP_QUERY;
            else if (r < 68) op = mtt_pkg::OP_EXPIRE;
            else if (r < 97) op = mtt_pkg::OP_TICK;
            else op = r[0] ? OP_SPARE_A : OP_SPARE_B;
            issue(op, pick_id(), pick_timeout());
            if (op != OP_SPARE_A && op != OP_SPARE_B) done_items++;
        end

        s_valid <= 1'b0;
        waited = 0;
        while (owed_results.size() != 0 && waited < 50000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (40) @(posedge aclk);
        if (owed_results.size() != 0) begin
            mismatches++;
            $error("%0d result beats never arrived", owed_results.size());
        end
        if (mismatches == 0) begin
            $display("multi_timer_table_tb: done, clean");
        end else begin
            $display("multi_timer_table_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/mtt_pkg.sv
rtl/core/mtt_ram.sv
rtl/core/mtt_engine.sv
rtl/core/multi_timer_table.sv
bench/multi_timer_table_tb.sv
